### hw/rtl/sml_tl_pkg.sv
package sml_tl_pkg;

  // Item kinds on the input channel
  typedef enum logic [2:0] {
    OP_EOM  = 3'd0,
    OP_BOOL = 3'd1,
    OP_UINT = 3'd2,
    OP_SINT = 3'd3,
    OP_OSTR = 3'd4,
    OP_LIST = 3'd5
  } op_e;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned CountW  = 28;
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned LenW    = 4;

  // Fixed bytes of the encoding
  localparam logic [7:0] BYTE_EOM     = 8'h00;
  localparam logic [7:0] BYTE_BOOL_TL = 8'h42;
  localparam logic [7:0] BYTE_TRUE    = 8'h7F;
  localparam logic [7:0] BYTE_FALSE   = 8'h00;
  localparam logic [7:0] TL_UINT_BASE = 8'h61;
  localparam logic [7:0] TL_SINT_BASE = 8'h51;
  localparam logic [2:0] TYPE_LIST    = 3'b111;
  localparam logic [2:0] TYPE_NONE    = 3'b000;

  // Encoded item: bytes left-aligned, first byte in the top bits
  typedef struct packed {
    logic [8*MaxBytes-1:0] bytes;
    logic [LenW-1:0]       len;
  } enc_t;

endpackage

### hw/rtl/sml_tl_field_encoder.sv
// SML type-length field encoder.
// Slave stream: one item per handshake, tdata carries operation [2:0],
// value [66:3] and count [94:67]; operation picks end of message, boolean,
// unsigned, signed, octet-string header or list header. Codes 6 and 7 are
// taken and dropped without output.
// Master stream: one encoded byte per handshake, most significant first,
// tlast high on the final byte of each item.
// The first byte of an item is valid once the item has passed the input
// register and been loaded into the output shifter. An item of L bytes
// (1 to 9) goes out one byte per handshake. The next item is loaded on
// the handshake of the previous last byte, so bytes flow with no gap, and
// the input register takes a new item while one is out.
// A stall on the master side holds the current byte and, once the input
// register is full, drops s_axis_tready_o.
// Reset empties the input register and the output shifter; no state
// survives between items.
module sml_tl_field_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // operation, value, count
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // out_byte
  output logic        m_axis_tlast_o    // last
);
  import sml_tl_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [OpW-1:0]    op_q;
  logic [ValueW-1:0] value_q;
  logic [CountW-1:0] count_q;
  logic              ser_ready;
  logic              in_take;
  enc_t              enc;

  assign s_axis_tready_o = !in_valid_q || ser_ready;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Track input register occupancy
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (ser_ready) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Capture the item fields
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= s_axis_tdata_i[2:0];
      value_q <= s_axis_tdata_i[66:3];
      count_q <= s_axis_tdata_i[94:67];
    end
  end

  sml_tl_enc u_enc (
    .op_i    (op_q),
    .value_i (value_q),
    .count_i (count_q),
    .enc_o   (enc)
  );

  sml_tl_ser u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .enc_i           (enc),
    .enc_valid_i     (in_valid_q),
    .ready_o         (ser_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

### hw/rtl/sml_tl_enc.sv
module sml_tl_enc (
  input  logic [2:0]            op_i,
  input  logic [63:0]           value_i,
  input  logic [27:0]           count_i,
  output sml_tl_pkg::enc_t      enc_o
);
  import sml_tl_pkg::*;

  logic [3:0]  uk;
  logic [3:0]  sk;
  logic [3:0]  on;
  logic [3:0]  ln;
  logic [3:0]  hn;
  logic [63:0] mask;
  logic [63:0] hi;
  logic [63:0] ones_hi;
  logic [35:0] lim;
  logic [31:0] tot;
  logic [31:0] aligned;
  logic        is_list;
  logic [7:0]  tl;
  logic [3:0]  ik;

  // Pick the byte widths for the unsigned and signed forms
  always_comb begin
    uk = 4'd8;
    for (int k = 7; k >= 1; k--) begin
      mask = (64'd1 << (8 * k)) - 64'd1;
      if (((value_i >> (8 * k)) == 64'd0) && ((value_i & mask) != mask)) begin
        uk = 4'(k);
      end
    end
    sk = 4'd8;
    for (int k = 4; k >= 1; k--) begin
      mask    = (64'd1 << (8 * k)) - 64'd1;
      hi      = value_i >> (8 * k - 1);
      ones_hi = {64{1'b1}} >> (8 * k - 1);
      if (((hi == 64'd0) && ((value_i & mask) != (mask >> 1))) ||
          ((hi == ones_hi) && ((value_i & mask) != ((mask >> 1) + 64'd1)))) begin
        sk = 4'(k);
      end
    end
  end

  // Nibble counts for the header forms
  always_comb begin
    on = 4'd8;
    for (int n = 7; n >= 1; n--) begin
      lim = (36'd1 << (4 * n)) - 36'(n);
      if ({8'd0, count_i} < lim) begin
        on = 4'(n);
      end
    end
    ln = 4'd8;
    for (int n = 7; n >= 1; n--) begin
      if ((count_i >> (4 * n)) == 28'd0) begin
        ln = 4'(n);
      end
    end
  end

  // Assemble the byte string
  always_comb begin
    enc_o   = '0;
    is_list = 1'b0;
    hn      = on;
    tot     = 32'(count_i) + 32'(on);
    aligned = '0;
    tl      = '0;
    ik      = 4'd8;
    unique case (op_i)
      OP_EOM: begin
        enc_o.bytes[71:64] = BYTE_EOM;
        enc_o.len          = 4'd1;
      end
      OP_BOOL: begin
        enc_o.bytes[71:64] = BYTE_BOOL_TL;
        enc_o.bytes[63:56] = (value_i != 64'd0) ? BYTE_TRUE : BYTE_FALSE;
        enc_o.len          = 4'd2;
      end
      OP_UINT, OP_SINT: begin
        ik = (op_i == OP_UINT) ? uk : sk;
        tl = ((op_i == OP_UINT) ? TL_UINT_BASE : TL_SINT_BASE) + 8'(ik);
        enc_o.bytes = {tl, value_i << {3'(4'd8 - ik), 3'b000}};
        enc_o.len   = ik + 4'd1;
      end
      OP_OSTR, OP_LIST: begin
        is_list = (op_i == OP_LIST);
        hn      = is_list ? ln : on;
        tot     = is_list ? 32'(count_i) : (32'(count_i) + 32'(on));
        aligned = tot << {3'(4'd8 - hn), 2'b00};
        for (int i = 0; i < 8; i++) begin
          enc_o.bytes[71 - 8 * i -: 8] = {
            (4'(i) + 4'd1 < hn),
            ((i == 0) && is_list) ? TYPE_LIST : TYPE_NONE,
            aligned[31 - 4 * i -: 4]
          };
        end
        enc_o.len = hn;
      end
      default: begin
        enc_o.len = '0;
      end
    endcase
  end

endmodule

### hw/rtl/sml_tl_ser.sv
module sml_tl_ser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sml_tl_pkg::enc_t  enc_i,
  input  logic              enc_valid_i,
  output logic              ready_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,   // out_byte
  output logic              m_axis_tlast_o    // last
);
  import sml_tl_pkg::*;

  logic [8*MaxBytes-1:0] sh_q, sh_d;
  logic [LenW-1:0]       rem_q, rem_d;
  logic                  take;
  logic                  load;

  assign take    = m_axis_tvalid_o && m_axis_tready_i;
  assign ready_o = (rem_q == '0) || ((rem_q == LenW'(1)) && take);
  assign load    = ready_o && enc_valid_i;

  // Load a new item or advance one byte
  always_comb begin
    sh_d  = sh_q;
    rem_d = rem_q;
    if (load) begin
      sh_d  = enc_i.bytes;
      rem_d = enc_i.len;
    end else if (take) begin
      sh_d  = {sh_q[8*MaxBytes-9:0], 8'h00};
      rem_d = rem_q - LenW'(1);
    end
  end

  // Hold the remaining byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // Hold the byte string
  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign m_axis_tvalid_o = (rem_q != '0);
  assign m_axis_tdata_o  = sh_q[8*MaxBytes-1 -: 8];
  assign m_axis_tlast_o  = (rem_q == LenW'(1));

endmodule
